// ----- rtl/spn_pkg.sv -----
// Shared constants, types and the job record for the sample peak normaliser.
// Depends on nothing; every other rtl file but spn_ram imports it.
`timescale 1ns / 1ps

package spn_pkg;

   localparam int SAMPLE_DEPTH = 4096;
   localparam int ADDR_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 15;
   localparam int PROD_W   = 32;
   localparam int MAG_W    = 31;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS = 15;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam logic               OP_PUSH      = 1'b0;
   localparam logic               OP_PULL      = 1'b1;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 15'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG     = 16'h8000;

   // One pull as handed from the front part to the back part.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] peak;
      logic                last;
      logic                valid;
   } job_type;

endpackage

// ----- rtl/spn_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module spn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/spn_front.sv -----
// Front part: takes commands, stores pushed samples, tracks the peak and
// turns each pull into a job for the queue. Depends on spn_pkg and spn_ram.
`timescale 1ns / 1ps

module spn_front
   import spn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [SAMPLE_W-1:0] req_sample_in,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job
);

   logic              pend_ff;
   logic              reading_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [SAMPLE_W-1:0] peak_ff;
   logic [SAMPLE_W-1:0] pend_peak_ff;
   logic              pend_last_ff;

   logic                accept;
   logic                push_ok;
   logic                pull_live;
   logic                pull_empty;
   logic                fin;
   logic [SAMPLE_W-1:0] mag;
   logic [SAMPLE_W-1:0] ram_q;

   assign busy   = pend_ff | q_full;
   assign accept = start & ~busy;

   assign push_ok    = accept && (req_opcode == OP_PUSH) && !reading_ff &&
                       (count_ff != CNT_W'(SAMPLE_DEPTH));
   assign pull_empty = accept && (req_opcode == OP_PULL) && (count_ff == '0);
   assign pull_live  = accept && (req_opcode == OP_PULL) && (count_ff != '0);
   assign fin        = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   // Magnitude; the most negative sample gives 32768, which still fits.
   assign mag = req_sample_in[SAMPLE_W-1] ? SAMPLE_W'(~req_sample_in + 1'b1)
                                          : req_sample_in;

   spn_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_sample_in),
      .rd_en   (pull_live),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         reading_ff <= 1'b0;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         peak_ff    <= '0;
      end else begin
         pend_ff <= pull_live;
         if (push_ok) begin
            count_ff <= count_ff + CNT_W'(1);
            if (mag > peak_ff) begin
               peak_ff <= mag;
            end
         end
         if (pull_live) begin
            if (fin) begin
               count_ff   <= '0;
               peak_ff    <= '0;
               rd_idx_ff  <= '0;
               reading_ff <= 1'b0;
            end else begin
               rd_idx_ff  <= rd_idx_ff + ADDR_W'(1);
               reading_ff <= 1'b1;
            end
         end
      end
   end

   // Peak and last are snapped with the read so the back part sees the wave
   // as it stood at the pull.
   always_ff @(posedge clock) begin
      if (pull_live) begin
         pend_peak_ff <= peak_ff;
         pend_last_ff <= fin;
      end
   end

   always_comb begin
      q_push = pend_ff | pull_empty;
      if (pend_ff) begin
         q_job.sample = ram_q;
         q_job.peak   = pend_peak_ff;
         q_job.last   = pend_last_ff;
         q_job.valid  = 1'b1;
      end else begin
         q_job.sample = '0;
         q_job.peak   = '0;
         q_job.last   = 1'b0;
         q_job.valid  = 1'b0;
      end
   end

endmodule

// ----- rtl/spn_fifo.sv -----
// Short job queue between the front and back parts.
// Depends on spn_pkg.
`timescale 1ns / 1ps

module spn_fifo
   import spn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  cnt_ff;

   assign full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_job = mem_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("job queue written while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job queue read while empty");

endmodule

// ----- rtl/spn_back.sv -----
// Back part: scales one job by target_level / peak with a multiply, a
// saturation check and a radix-2 restoring divide. Depends on spn_pkg.
`timescale 1ns / 1ps

module spn_back
   import spn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [LEVEL_W-1:0]  target_level,
   input  logic                q_empty,
   input  job_type             q_job,
   output logic                q_pop,
   output logic                rsp_strobe,
   output logic [SAMPLE_W-1:0] rsp_sample_out,
   output logic                rsp_last,
   output logic                rsp_valid_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ABS,
      ST_CHK,
      ST_DIV
   } state_type;

   state_type                  state_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0]        peak_ff;
   logic                       last_ff;
   logic                       valid_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic [SAMPLE_W-1:0]        rem_ff;
   logic [DIV_STEPS-1:0]       dvd_ff;
   logic [DIV_STEPS-1:0]       quo_ff;
   logic [DCNT_W-1:0]          step_ff;
   logic                       strobe_ff;
   logic [SAMPLE_W-1:0]        out_ff;
   logic                       out_last_ff;
   logic                       out_valid_ff;

   logic signed [SAMPLE_W-1:0] level_s;
   logic [SAMPLE_W:0]          trial;
   logic                       ge;
   logic [SAMPLE_W-1:0]        rem_in;
   logic [DIV_STEPS-1:0]       quo_in;
   logic [SAMPLE_W-1:0]        res_in;

   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign level_s = $signed({1'b0, target_level});

   // One quotient bit per cycle; the remainder always stays below the peak.
   assign trial  = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign ge     = trial >= {1'b0, peak_ff};
   assign rem_in = ge ? SAMPLE_W'(trial - {1'b0, peak_ff}) : trial[SAMPLE_W-1:0];
   assign quo_in = {quo_ff[DIV_STEPS-2:0], ge};
   assign res_in = neg_ff ? SAMPLE_W'(-{1'b0, quo_in}) : {1'b0, quo_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  sample_ff <= q_job.sample;
                  peak_ff   <= q_job.peak;
                  last_ff   <= q_job.last;
                  valid_ff  <= q_job.valid;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(sample_ff) * PROD_W'(level_s);
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               neg_ff   <= prod_ff[PROD_W-1];
               mag_ff   <= MAG_W'(prod_ff[PROD_W-1] ? -prod_ff : prod_ff);
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               out_last_ff  <= last_ff;
               out_valid_ff <= valid_ff;
               if (!valid_ff) begin
                  out_ff      <= '0;
                  out_last_ff <= 1'b0;
                  strobe_ff   <= 1'b1;
                  state_ff    <= ST_IDLE;
               end else if (peak_ff == '0) begin
                  out_ff    <= sample_ff;
                  strobe_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else if (mag_ff >= {peak_ff, {DIV_STEPS{1'b0}}}) begin
                  // Quotient would not fit: clamp by sign.
                  out_ff    <= neg_ff ? SAT_NEG : SAT_POS;
                  strobe_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else begin
                  rem_ff   <= mag_ff[MAG_W-1:DIV_STEPS];
                  dvd_ff   <= mag_ff[DIV_STEPS-1:0];
                  quo_ff   <= '0;
                  step_ff  <= DCNT_W'(DIV_STEPS - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               dvd_ff  <= {dvd_ff[DIV_STEPS-2:0], 1'b0};
               quo_ff  <= quo_in;
               step_ff <= step_ff - DCNT_W'(1);
               if (step_ff == '0) begin
                  out_ff    <= res_in;
                  strobe_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_sample_out = out_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_valid_res  = out_valid_ff;

   a_strobe_source : assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == ST_CHK || $past(state_ff) == ST_DIV))
      else $error("result strobe outside a finishing state");
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !out_valid_ff) |-> (!out_last_ff && out_ff == '0))
      else $error("empty pull returned data");

endmodule

// ----- rtl/sample_peak_normalizer.sv -----
// Top level of the sample peak normaliser: configuration register and the
// wiring of front part, job queue and back part. Depends on spn_pkg,
// spn_front, spn_fifo and spn_back.
`timescale 1ns / 1ps

// Usage
//   Command channel: a transfer happens on a rising edge with start high and
//   busy low. req_opcode selects push (store req_sample_in, track the peak)
//   or pull (return the next stored sample scaled by target_level / peak).
//   Pushes are dropped when the store is full or once a readout has begun.
//   Result channel: rsp_strobe is high for exactly one cycle per pull with
//   rsp_sample_out, rsp_last and rsp_valid_res. The receiver cannot stall;
//   every result must be taken in its strobe cycle.
//   Configuration: csr_wr_en writes target_level (csr_wr_data) on that edge.
//   Write it only while no pull is outstanding.
// Flow
//   A pull holds the front while its store read is in flight, then waits in
//   a two-entry job queue for the back part. The back part takes a pull
//   that needs the divider through pop, multiply, magnitude, range check
//   and 15 divide steps, and an empty pull, a zero peak or a saturated
//   result through pop, multiply, magnitude and range check only. It pops
//   the next job only from idle, so it ends one pull before the next.
//   busy rises while the queue is full or a store read is in flight.
// Reset
//   Synchronous, active high: empties the store count, peak, read position
//   and queue, and sets target_level to 32767. No clearing pass is needed.

module sample_peak_normalizer
   import spn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [SAMPLE_W-1:0] req_sample_in,
   output logic                rsp_strobe,
   output logic [SAMPLE_W-1:0] rsp_sample_out,
   output logic                rsp_last,
   output logic                rsp_valid_res,
   input  logic                csr_wr_en,
   input  logic [LEVEL_W-1:0]  csr_wr_data
);

   logic [LEVEL_W-1:0] target_level_ff;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type q_in_job;
   job_type q_head_job;

   // Gain numerator; only read by the back part while a job is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_level_ff <= LEVEL_RESET;
      end else if (csr_wr_en) begin
         target_level_ff <= csr_wr_data;
      end
   end

   spn_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_sample_in (req_sample_in),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_in_job)
   );

   spn_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   spn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .target_level   (target_level_ff),
      .q_empty        (q_empty),
      .q_job          (q_head_job),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last       (rsp_last),
      .rsp_valid_res  (rsp_valid_res)
   );

endmodule

// ----- verif/tb_sample_peak_normalizer.sv -----
// Self-checking testbench for sample_peak_normalizer: drives push and pull
// commands and target_level writes, and checks every result strobe against
// its own model of the wave store. Depends on spn_pkg and the rtl top level.
`timescale 1ns / 1ps

module tb_sample_peak_normalizer;
   import spn_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
   localparam int SETTLE_CYCLES  = 30;    // longer than one pull through the divider
   localparam int RANDOM_ITEMS   = 1500;

   // One expected transfer on the result channel.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                valid;
   } norm_result_type;

   // Flavours of sample content for a random wave.
   typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_ZERO} mix_type;

   // Keeps its own copy of the wave store, peak and read position, works out
   // the normalised sample for every pull and checks results in order.
   class norm_scoreboard;
      logic [SAMPLE_W-1:0] wave_store [SAMPLE_DEPTH];
      int unsigned         fill;
      int unsigned         peak;
      int unsigned         read_pos;
      bit                  reading;
      logic [LEVEL_W-1:0]  level = LEVEL_RESET;
      norm_result_type     awaited [$];
      int unsigned         mismatches;
      int unsigned         checked;

      function logic [SAMPLE_W-1:0] scaled(logic [SAMPLE_W-1:0] raw);
         longint q;
         if (peak == 0)
            return raw;
         // SV division truncates toward zero, as the block must
         q = (longint'($signed(raw)) * longint'(level)) / longint'(peak);
         if (q > 32767)
            q = 32767;
         if (q < -32768)
            q = -32768;
         return q[SAMPLE_W-1:0];
      endfunction

      function void note_command(logic op, logic [SAMPLE_W-1:0] smp);
         norm_result_type r;
         int              sv;
         int unsigned     mag;
         if (op == OP_PUSH) begin
            if (reading || fill >= SAMPLE_DEPTH)
               return;
            sv  = $signed(smp);
            mag = (sv < 0) ? -sv : sv;
            wave_store[fill] = smp;
            fill++;
            if (mag > peak)
               peak = mag;
            return;
         end
         if (fill == 0) begin
            r = '{sample: '0, last: 1'b0, valid: 1'b0};
            awaited.push_back(r);
            return;
         end
         reading = 1'b1;
         if (read_pos >= fill)
            read_pos = 0;
         r.sample = scaled(wave_store[read_pos]);
         read_pos++;
         r.last  = (read_pos >= fill);
         r.valid = 1'b1;
         if (r.last) begin
            fill     = 0;
            peak     = 0;
            read_pos = 0;
            reading  = 1'b0;
         end
         awaited.push_back(r);
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] smp, logic lst, logic vld);
         norm_result_type e;
         checked++;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result: sample %0d last %b valid %b",
                     $time, $signed(smp), lst, vld);
            mismatches++;
            return;
         end
         e = awaited.pop_front();
         if (e.sample !== smp) begin
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, $signed(e.sample), $signed(smp));
            mismatches++;
         end
         if (e.last !== lst) begin
            $display("%0t: last expected %b actual %b", $time, e.last, lst);
            mismatches++;
         end
         if (e.valid !== vld) begin
            $display("%0t: valid_res expected %b actual %b", $time, e.valid, vld);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_opcode;
   logic [SAMPLE_W-1:0] req_sample_in;
   logic                rsp_strobe;
   logic [SAMPLE_W-1:0] rsp_sample_out;
   logic                rsp_last;
   logic                rsp_valid_res;
   logic                csr_wr_en;
   logic [LEVEL_W-1:0]  csr_wr_data;

   norm_scoreboard norm_sb;
   bit             gaps_on = 1'b1;
   int unsigned    n_items, n_push, n_pull, n_waves, n_level_writes;
   int unsigned    quiet_cycles;

   sample_peak_normalizer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_sample_in  (req_sample_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last       (rsp_last),
      .rsp_valid_res  (rsp_valid_res),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Outputs are sampled on the falling edge, clear of the rising edge where
   // the block and the driver both update.
   always @(negedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         norm_sb.check_result(rsp_sample_out, rsp_last, rsp_valid_res);
   end

   // Watchdog: any command transfer or result strobe counts as progress.
   always @(negedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Called just after a rising edge; returns just after the edge of the
   // transfer. Random idle cycles go before the command, with junk on the
   // request fields while start is low. start stays high into the next
   // command when there is no gap.
   task automatic send_command(input logic op, input logic [SAMPLE_W-1:0] smp);
      while (gaps_on && $urandom_range(99) < 21) begin
         start         <= 1'b0;
         req_opcode    <= 1'($urandom);
         req_sample_in <= SAMPLE_W'($urandom);
         @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_sample_in <= smp;
      // busy seen low on the falling edge means the transfer happens next edge
      do @(negedge clock); while (busy !== 1'b0);
      norm_sb.note_command(op, smp);
      n_items++;
      if (op == OP_PUSH)
         n_push++;
      else
         n_pull++;
      @(posedge clock);
   endtask

   task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
      send_command(OP_PUSH, smp);
   endtask

   task automatic pull_sample();
      send_command(OP_PULL, SAMPLE_W'($urandom));
   endtask

   // Sender holds off until every awaited result is in, then lets the back
   // part finish anything still in flight.
   task automatic drain_results();
      start <= 1'b0;
      while (norm_sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle, after reset or straight after drain_results.
   task automatic write_level(input logic [LEVEL_W-1:0] lvl);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lvl;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      norm_sb.level = lvl;
      n_level_writes++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(mix_type mix);
      case (mix)
         MIX_FULL:  return SAMPLE_W'($urandom);
         MIX_SMALL: return SAMPLE_W'(int'($urandom_range(62)) - 31);
         MIX_EXTREME: begin
            case ($urandom_range(3))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
         default:   return '0;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level();
      int unsigned v;
      v = $urandom_range(99);
      if (v < 10)
         return '0;
      if (v < 20)
         return LEVEL_RESET;
      return LEVEL_W'($urandom_range(32767));
   endfunction

   // One wave with random content. Now and then a pull breaks into the
   // pushes, a push lands in the readout (dropped) or a pull finds the
   // store empty afterwards.
   task automatic random_wave(input int unsigned len);
      mix_type     mix;
      int unsigned v;
      v = $urandom_range(99);
      mix = (v < 55) ? MIX_FULL : (v < 80) ? MIX_SMALL : (v < 95) ? MIX_EXTREME : MIX_ZERO;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(99) < 3)
            pull_sample();
         push_sample(pick_sample(mix));
      end
      while (norm_sb.fill != 0) begin
         if ($urandom_range(99) < 8)
            push_sample(pick_sample(MIX_FULL));
         else
            pull_sample();
      end
      if ($urandom_range(99) < 20)
         pull_sample();
      n_waves++;
   endtask

   initial begin
      norm_sb       = new;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_opcode    <= OP_PUSH;
      req_sample_in <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      write_level(LEVEL_RESET);
      pull_sample();                      // nothing stored: valid_res low
      push_sample(16'h0000);              // all-zero wave: peak stays zero,
      push_sample(16'h0000);              // samples pass straight through
      pull_sample();
      pull_sample();
      push_sample(16'h7FFF);              // both field extremes; -32768 is
      push_sample(16'h8000);              // magnitude 32768, so it sets peak
      push_sample(16'h0001);
      push_sample(16'hFFFF);
      pull_sample();
      push_sample(16'h0005);              // readout under way: dropped
      pull_sample();
      pull_sample();
      pull_sample();
      pull_sample();                      // wave cleared: empty again
      drain_results();
      write_level('0);                    // zero target flattens everything
      push_sample(16'd1234);
      push_sample(-16'sd7);
      pull_sample();
      pull_sample();
      drain_results();
      write_level(15'd1);
      push_sample(16'h8000);
      pull_sample();
      drain_results();
      write_level(LEVEL_RESET);           // tiny peak, full target: output
      push_sample(16'd3);                 // hits the top of the range, and a
      push_sample(-16'sd2);               // negative quotient truncates toward zero
      pull_sample();
      pull_sample();
      drain_results();

      // ---- random waves ----
      while (n_items < RANDOM_ITEMS) begin
         // a long stretch with no idle cycles on the sender side
         gaps_on = !(n_waves >= 40 && n_waves < 70);
         random_wave(($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                               : $urandom_range(13, 48));
         if ($urandom_range(99) < 25) begin
            drain_results();
            if ($urandom_range(99) < 60)
               write_level(pick_level());
         end
      end
      gaps_on = 1'b1;

      drain_results();
      $display("Covered %0d pushes and %0d pulls over %0d waves, %0d results checked,",
               n_push, n_pull, n_waves, norm_sb.checked);
      $display("with %0d target_level writes between waves", n_level_writes);
      if (norm_sb.mismatches == 0 && norm_sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         if (norm_sb.outstanding() != 0)
            $display("%0t: %0d results never arrived", $time, norm_sb.outstanding());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
